// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the serial frame deframer
// frame layout, byte position codes, status codes and the result record
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame marker bytes
  localparam logic [7:0] HEADER_BYTE  = 8'hAA;
  localparam logic [7:0] TRAILER_BYTE = 8'h55;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned PAYLOAD_N = 4;

  // status codes carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_TRAILER  = 3'd4
  } status_t;

  // position within the frame, i.e. which byte is expected next
  typedef enum logic [2:0] {
    POS_HUNT  = 3'd0,
    POS_PAY1  = 3'd1,
    POS_PAY2  = 3'd2,
    POS_PAY3  = 3'd3,
    POS_PAY4  = 3'd4,
    POS_CSUM  = 3'd5,
    POS_TRAIL = 3'd6
  } pos_t;

  // per-byte result handed from the frame tracker to the output stage
  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;
  } sfd_result_t;

endpackage
`default_nettype wire

// ===== rtl/sfd_frame_track.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_frame_track: frame position tracking and per-byte status
// holds the byte position, payload bytes and running checksum; gives the
// status of the current byte combinationally and updates state on accept
// ----------------------------------------------------------------------------
module sfd_frame_track
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,   // byte transaction accepted
  input  wire logic [BYTE_W-1:0] rx_byte,
  output sfd_result_t            result
);

  pos_t              pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] payload_r [PAYLOAD_N];

  // next position and running checksum
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    unique case (pos_r)
      POS_PAY1, POS_PAY2, POS_PAY3: begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_t'(pos_r + 3'd1);
      end
      POS_PAY4: begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = POS_CSUM;
      end
      POS_CSUM: begin
        sum_nxt = sum_r - rx_byte;
        pos_nxt = POS_TRAIL;
      end
      POS_TRAIL: begin
        pos_nxt = POS_HUNT;
      end
      default: begin
        // hunting, and the unused position code
        if (rx_byte == HEADER_BYTE) begin
          sum_nxt = '0;
          pos_nxt = POS_PAY1;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end
    endcase
  end

  // status and decoded values for the current byte
  always_comb begin
    result.status       = ST_ACCEPTED;
    result.first_value  = '0;
    result.second_value = '0;
    unique case (pos_r)
      POS_PAY1, POS_PAY2, POS_PAY3, POS_PAY4, POS_CSUM: begin
        result.status = ST_ACCEPTED;
      end
      POS_TRAIL: begin
        // trailer is checked before the checksum
        if (rx_byte != TRAILER_BYTE) begin
          result.status = ST_TRAILER;
        end else if (sum_r != '0) begin
          result.status = ST_CHECKSUM;
        end else begin
          result.status       = ST_GOOD;
          result.first_value  = {payload_r[1], payload_r[0]};
          result.second_value = {payload_r[3], payload_r[2]};
        end
      end
      default: begin
        if (rx_byte != HEADER_BYTE) begin
          result.status = ST_DROPPED;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
    end else if (byte_en) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // payload capture, one fixed slot per payload position
  always_ff @(posedge clk) begin
    if (byte_en) begin
      if (pos_r == POS_PAY1) payload_r[0] <= rx_byte;
      if (pos_r == POS_PAY2) payload_r[1] <= rx_byte;
      if (pos_r == POS_PAY3) payload_r[2] <= rx_byte;
      if (pos_r == POS_PAY4) payload_r[3] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/serial_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_deframer: byte stream to frame status and values
// finds 0xAA / 4 payload / checksum / 0x55 frames in a byte stream
// ----------------------------------------------------------------------------
// Every received byte gives exactly one result transaction, in the cycle
// after the byte is taken. One byte is accepted per cycle: the frame state
// update is a single short step and the result sits in one output register,
// which is refilled in the same cycle it is drained, so in_tready stays high
// unless a result is waiting while out_tready is low. out_tuser carries the
// status (accepted, frame good, checksum error, dropped while hunting, bad
// trailer); out_tdata carries the two signed little-endian payload words,
// which are zero unless the status is frame good. Any error returns the block
// to hunting for the header byte.
// ----------------------------------------------------------------------------
module serial_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // received bytes
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  // per-byte results
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*VALUE_W-1:0]       out_tdata,  // [15:0] first_value, [31:16] second_value
  output logic [STATUS_W-1:0]        out_tuser   // [2:0] status
);

  logic        in_fire;
  sfd_result_t track_result;
  sfd_result_t result_r;
  logic        out_valid_r;

  // output register can take a new result when empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  sfd_frame_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_fire),
    .rx_byte (in_tdata),
    .result  (track_result)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= track_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = result_r.status;
  assign out_tdata  = {result_r.second_value, result_r.first_value};

endmodule
`default_nettype wire

// ===== rtl/sfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks for the serial frame deframer
// watches the top level's ports and flags behaviour the block must not show
// ----------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [2*VALUE_W-1:0]  out_tdata,
  input wire logic [STATUS_W-1:0]   out_tuser
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // every accepted byte yields a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted byte gave no result");

  // empty output stage never stalls the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_ACCEPTED || out_tuser == ST_GOOD ||
                    out_tuser == ST_CHECKSUM || out_tuser == ST_DROPPED ||
                    out_tuser == ST_TRAILER))
    else $error("undefined status code");

  // values only carried on a good frame
  a_values_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_GOOD) |-> (out_tdata == '0))
    else $error("values present without a good frame");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (.*);
`default_nettype wire
